@@ src/ipa_pkg.sv @@
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared constants and types for the interval partition assigner: heap
// sizing, time width, stream data widths and the heap entry layout.
// ----------------------------------------------------------------------------
package ipa_pkg;

   localparam int MAX_RESOURCES = 64;
   localparam int TIME_BITS     = 32;

   localparam int ADDR_BITS = $clog2(MAX_RESOURCES);
   localparam int CNT_BITS  = $clog2(MAX_RESOURCES + 1);

   localparam int RSP_FIELD_BITS = 7;
   localparam int REQ_TDATA_W    = ((2 * TIME_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W    = ((2 * RSP_FIELD_BITS + 7) / 8) * 8;

   // End time in the top bits so a plain unsigned compare orders entries
   // by end, then start, then resource number.
   typedef struct packed {
      logic [TIME_BITS-1:0] end_time;
      logic [TIME_BITS-1:0] start_time;
      logic [CNT_BITS-1:0]  resource;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   function automatic logic [RSP_FIELD_BITS-1:0] to_rsp_field(logic [CNT_BITS-1:0] v);
      logic [CNT_BITS+RSP_FIELD_BITS-1:0] w;
      w = (CNT_BITS + RSP_FIELD_BITS)'(v);
      return w[RSP_FIELD_BITS-1:0];
   endfunction

endpackage

@@ src/interval_partition_assigner.sv @@
// ----------------------------------------------------------------------------
// interval_partition_assigner
// Assigns each booking [start, end) a resource number using a min-heap of
// busy resources kept in RAM, sifted one level at a time by a small
// sequencer around a single shared entry comparator.
//
// channel  dir  handshake            payload
// req_     in   req_tvalid/tready    tdata: start_time, end_time; tuser: first_booking
// rsp_     out  rsp_tvalid/tready    tdata: resource_number, resources_used; tuser: overflow
//
// One booking at a time; req_tready is high only while idle.
// Insert sifts up one heap level at a time (read parent, compare with
// booking); reuse sifts down one level at a time (read children, pick child,
// compare with booking). After each result the sequencer returns to idle
// before the next beat is taken.
// A finished result waits in the output register; the next beat is taken
// meanwhile and stalls only at its own result until rsp_tready.
// Synchronous reset empties the heap count and the output register.
// ----------------------------------------------------------------------------
module interval_partition_assigner
   import ipa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // start_time, end_time
   input  logic                   req_tuser,  // first_booking
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // resource_number, resources_used, zero pad
   output logic                   rsp_tuser   // overflow
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_UP     = 3'd2;
   localparam logic [2:0] S_UPCMP  = 3'd3;
   localparam logic [2:0] S_DOWN   = 3'd4;
   localparam logic [2:0] S_PICK   = 3'd5;
   localparam logic [2:0] S_DNCMP  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS-1:0] bpos_ff, bpos_in;
   entry_type            cur_ff, cur_in;
   entry_type            best_ff, best_in;
   logic [CNT_BITS-1:0]  res_ff, res_in;
   logic                 ovf_ff, ovf_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_FIELD_BITS-1:0] rsp_res_ff, rsp_res_in;
   logic [RSP_FIELD_BITS-1:0] rsp_used_ff, rsp_used_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] wr_addr;
   entry_type            wr_data;
   logic [ADDR_BITS-1:0] rd_addr_a;
   logic [ADDR_BITS-1:0] rd_addr_b;
   entry_type            rd_data_a;
   entry_type            rd_data_b;

   entry_type            cmp_a;
   entry_type            cmp_b;
   logic                 a_before_b;

   logic [ADDR_BITS-1:0] parent;
   logic [ADDR_BITS+1:0] left_w;
   logic [ADDR_BITS+1:0] right_w;
   logic [ADDR_BITS+1:0] cnt_w;
   logic [CNT_BITS-1:0]  cnt_inc;

   ipa_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_RESOURCES)
   ) u_heap (
      .clock     (clock),
      .we        (ram_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // shared entry comparator
   assign a_before_b = cmp_a < cmp_b;

   assign parent  = ADDR_BITS'((pos_ff - ADDR_BITS'(1)) >> 1);
   assign left_w  = {1'b0, pos_ff, 1'b1};
   assign right_w = left_w + (ADDR_BITS + 2)'(1);
   assign cnt_w   = (ADDR_BITS + 2)'(cnt_ff);
   assign cnt_inc = cnt_ff + CNT_BITS'(1);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      bpos_in  = bpos_ff;
      cur_in   = cur_ff;
      best_in  = best_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      ram_we    = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;
      cmp_a     = cur_ff;
      cmp_b     = rd_data_a;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cur_in.start_time = req_tdata[TIME_BITS-1:0];
               cur_in.end_time   = req_tdata[2*TIME_BITS-1:TIME_BITS];
               cnt_in            = req_tuser ? '0 : cnt_ff;
               state_in          = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // start before top end, through the shared comparator
            cmp_a          = '0;
            cmp_a.end_time = cur_ff.start_time;
            cmp_b          = '0;
            cmp_b.end_time = rd_data_a.end_time;
            ovf_in = 1'b0;
            if (cnt_ff == '0 || a_before_b) begin
               if (cnt_ff == CNT_BITS'(MAX_RESOURCES)) begin
                  ovf_in   = 1'b1;
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  res_in          = cnt_inc;
                  cnt_in          = cnt_inc;
                  pos_in          = cnt_ff[ADDR_BITS-1:0];
                  cur_in.resource = cnt_inc;
                  state_in        = S_UP;
               end
            end else begin
               res_in          = rd_data_a.resource;
               cur_in.resource = rd_data_a.resource;
               pos_in          = '0;
               state_in        = S_DOWN;
            end
         end
         S_UP: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = parent;
               state_in  = S_UPCMP;
            end
         end
         S_UPCMP: begin
            ram_we = 1'b1;
            if (a_before_b) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DOWN: begin
            if (left_w >= cnt_w) begin
               ram_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = left_w[ADDR_BITS-1:0];
               rd_addr_b = right_w[ADDR_BITS-1:0];
               state_in  = S_PICK;
            end
         end
         S_PICK: begin
            cmp_a = rd_data_b;
            if (right_w < cnt_w && a_before_b) begin
               best_in = rd_data_b;
               bpos_in = right_w[ADDR_BITS-1:0];
            end else begin
               best_in = rd_data_a;
               bpos_in = left_w[ADDR_BITS-1:0];
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            cmp_a  = best_ff;
            cmp_b  = cur_ff;
            ram_we = 1'b1;
            if (a_before_b) begin
               wr_data  = best_ff;
               pos_in   = bpos_ff;
               state_in = S_DOWN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = to_rsp_field(res_ff);
               rsp_used_in  = to_rsp_field(cnt_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      bpos_ff     <= bpos_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      ovf_ff      <= ovf_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_used_ff <= rsp_used_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 2 * RSP_FIELD_BITS)'(0), rsp_used_ff, rsp_res_ff};
   assign rsp_tuser  = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_RESOURCES))
      else $error("heap count above capacity");

   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CNT_BITS'(wr_addr) < cnt_ff))
      else $error("heap write outside occupied entries");

   a_res_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !ovf_ff) |-> (res_ff != '0 && res_ff <= cnt_ff))
      else $error("assigned resource outside opened range");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && ovf_ff) |-> (res_ff == '0 && cnt_ff == CNT_BITS'(MAX_RESOURCES)))
      else $error("overflow without full heap");
`endif

endmodule

@@ src/ipa_ram.sv @@
// ----------------------------------------------------------------------------
// ipa_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ipa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
